// ===== rtl/audio_crossfade_mixer_assert.svh =====
// Assertion macros for the crossfade mixer RTL.
`ifndef AUDIO_CROSSFADE_MIXER_ASSERT_SVH
`define AUDIO_CROSSFADE_MIXER_ASSERT_SVH
`ifndef SYNTH
// Consequent checked in the same cycle as the antecedent.
`define ACM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define ACM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ACM_ASSERT_SAME(label, ante, cons, msg)
`define ACM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/acm_pkg.sv =====
// Shared types, constants and the sine table generator for the crossfade mixer.
`default_nettype none
package acm_pkg;

	// configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CTRL_BITS      = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_CONTROL_LOW  = 2'd0,
		CFG_CONTROL_HIGH = 2'd1,
		CFG_PANNING_LAW  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		LAW_LINEAR      = 1'b0,
		LAW_EQUAL_POWER = 1'b1
	} law_t;

	localparam logic signed [CTRL_BITS-1:0] CTL_LOW_RESET  = -32'sd65536;
	localparam logic signed [CTRL_BITS-1:0] CTL_HIGH_RESET = 32'sd65536;
	localparam law_t                        LAW_RESET      = LAW_EQUAL_POWER;

	// position and gain formats
	localparam int T_BITS    = 17;          // Q1.16 position, 0..1.0 inclusive
	localparam int FRAC_BITS = 16;
	localparam int PROD_BITS = T_BITS + FRAC_BITS;
	localparam int DIV_STEPS = T_BITS;      // one quotient bit per divider stage
	localparam logic [T_BITS-1:0] UNITY_Q16 = 17'h10000;
	localparam int ROUND_HALF = 32768;

	// sine table generation (elaboration only)
	localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
	localparam int          TAYLOR_TERMS = 12;

	// sin(x) for x in Q2.30, truncated Taylor terms, rounded half up to Q16, capped at 1.0
	function automatic logic [T_BITS-1:0] sine_q16(input logic [63:0] x);
		logic signed [63:0] sum;
		logic [63:0]        term;
		logic [63:0]        rnd;
		sum  = $signed(x);
		term = x;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		rnd = ($unsigned(sum) + 64'd8192) >> 14;
		if (rnd > 64'(UNITY_Q16)) begin
			rnd = 64'(UNITY_Q16);
		end
		return rnd[T_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/audio_crossfade_mixer.sv =====
// Crossfade mixer top level: bounds, pipelined position divider, gain law and weighted sum.
//
// Channel   Dir  Transfer rule                 Contents
// s_axis    in   tvalid & tready               sample_a, sample_b, control_value
// m_axis    out  tvalid & tready               mixed_sample (tdata), saturated (tuser)
// cfg       in   cfg_wr_en                     control_low, control_high, panning_law
//
// One transaction per cycle sustained while m_axis_tready holds high; 26 register stages, the last
// of which drives m_axis_tvalid. 17 of those stages are the restoring divider that forms the
// Q1.16 position, one bit each.
// Reset clears the valid bits and restores the register defaults; payload is not reset.
// Each stage loads when it is empty or the stage after it moves, so a stall on m_axis
// fills bubbles first and then holds every stage in place.
`default_nettype none
`include "audio_crossfade_mixer_assert.svh"
module audio_crossfade_mixer
	import acm_pkg::*;
#(
	parameter int SAMPLE_BITS        = 24,
	parameter int GAIN_TABLE_ENTRIES = 256,
	localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + CTRL_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration writes
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// input stream
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,  // sample_a, sample_b, control_value, zero pad
	// output stream
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,  // mixed_sample, zero pad
	output logic [0:0]                m_axis_tuser   // saturated
);

	localparam int SB         = SAMPLE_BITS;
	localparam int IDX_BITS   = $clog2(GAIN_TABLE_ENTRIES + 1);
	localparam int POS_BITS   = FRAC_BITS + IDX_BITS;
	localparam int MUL_BITS   = SB + T_BITS + 1;
	localparam int ACC_BITS   = MUL_BITS + 1;
	localparam int Q_BITS     = ACC_BITS - FRAC_BITS;
	localparam logic [IDX_BITS-1:0] TBL_LAST = IDX_BITS'(GAIN_TABLE_ENTRIES);
	localparam logic [POS_BITS-1:0] TBL_N    = POS_BITS'(GAIN_TABLE_ENTRIES);
	localparam logic signed [Q_BITS-1:0] SAT_HI =
		Q_BITS'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [Q_BITS-1:0] SAT_LO = ~SAT_HI;

	// ---------------------------------------------------------------- config registers
	logic signed [CTRL_BITS-1:0] ctl_low_q;
	logic signed [CTRL_BITS-1:0] ctl_high_q;
	law_t                        law_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_low_q  <= CTL_LOW_RESET;
			ctl_high_q <= CTL_HIGH_RESET;
			law_q      <= LAW_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CONTROL_LOW:  ctl_low_q  <= $signed(cfg_data[CTRL_BITS-1:0]);
				CFG_CONTROL_HIGH: ctl_high_q <= $signed(cfg_data[CTRL_BITS-1:0]);
				CFG_PANNING_LAW:  law_q      <= law_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- quarter-wave sine table
	logic [T_BITS-1:0] sine_rom [GAIN_TABLE_ENTRIES+1];

	for (genvar i = 0; i <= GAIN_TABLE_ENTRIES; i++) begin : g_sine_rom
		localparam logic [63:0] ANGLE_Q30 =
			(HALF_PI_Q30 * 64'(i)) / 64'(GAIN_TABLE_ENTRIES);
		localparam logic [T_BITS-1:0] SINE_VAL = sine_q16(ANGLE_Q30);
		assign sine_rom[i] = SINE_VAL;
	end

	// ---------------------------------------------------------------- stage enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	wire  [DIV_STEPS-1:0] div_en;
	logic div_vld_sd [DIV_STEPS];

	assign en_s9 = !vld_s9 || m_axis_tready;
	assign en_s8 = !vld_s8 || en_s9;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || div_en[0];
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// ---------------------------------------------------------------- s1: unpack, order bounds
	logic signed [SB-1:0]        a_s1, b_s1;
	logic signed [CTRL_BITS-1:0] c_s1, lo_s1, hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_s1 <= $signed(s_axis_tdata[SB-1:0]);
			b_s1 <= $signed(s_axis_tdata[2*SB-1:SB]);
			c_s1 <= $signed(s_axis_tdata[2*SB+CTRL_BITS-1:2*SB]);
			if (ctl_low_q > ctl_high_q) begin
				lo_s1 <= ctl_high_q;
				hi_s1 <= ctl_low_q;
			end else begin
				lo_s1 <= ctl_low_q;
				hi_s1 <= ctl_high_q;
			end
		end
	end

	// ---------------------------------------------------------------- s2: clamp, range
	logic signed [SB-1:0]        a_s2, b_s2;
	logic signed [CTRL_BITS-1:0] cc_s2, lo_s2;
	logic [CTRL_BITS-1:0]        rng_s2;
	logic [CTRL_BITS:0]          span;

	assign span = {hi_s1[CTRL_BITS-1], hi_s1} - {lo_s1[CTRL_BITS-1], lo_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			lo_s2 <= lo_s1;
			if (c_s1 < lo_s1) begin
				cc_s2 <= lo_s1;
			end else if (c_s1 > hi_s1) begin
				cc_s2 <= hi_s1;
			end else begin
				cc_s2 <= c_s1;
			end
			// equal bounds divide by one LSB
			rng_s2 <= (hi_s1 == lo_s1) ? CTRL_BITS'(1) : span[CTRL_BITS-1:0];
		end
	end

	// ---------------------------------------------------------------- s3: numerator
	logic signed [SB-1:0] a_s3, b_s3;
	logic [CTRL_BITS-1:0] num_s3, rng_s3;
	logic [CTRL_BITS:0]   num_full;

	assign num_full = {cc_s2[CTRL_BITS-1], cc_s2} - {lo_s2[CTRL_BITS-1], lo_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			num_s3 <= num_full[CTRL_BITS-1:0];
			rng_s3 <= rng_s2;
		end
	end

	// ---------------------------------------------------------------- divider: one quotient bit per stage
	logic [CTRL_BITS-1:0] div_rem_sd [DIV_STEPS];
	logic [CTRL_BITS-1:0] div_rng_sd [DIV_STEPS];
	logic [T_BITS-1:0]    div_quo_sd [DIV_STEPS];
	logic signed [SB-1:0] div_a_sd   [DIV_STEPS];
	logic signed [SB-1:0] div_b_sd   [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic                 vld_in;
		logic [CTRL_BITS-1:0] rem_in, rng_in;
		logic [T_BITS-1:0]    quo_in;
		logic signed [SB-1:0] a_in, b_in;
		logic [CTRL_BITS:0]   trial;
		logic                 qbit;

		if (k == 0) begin : g_first
			// remainder starts at num <= range, so no doubling on the top bit
			assign vld_in = vld_s3;
			assign rem_in = num_s3;
			assign rng_in = rng_s3;
			assign quo_in = '0;
			assign a_in   = a_s3;
			assign b_in   = b_s3;
			assign trial  = {1'b0, rem_in};
		end else begin : g_next
			assign vld_in = div_vld_sd[k-1];
			assign rem_in = div_rem_sd[k-1];
			assign rng_in = div_rng_sd[k-1];
			assign quo_in = div_quo_sd[k-1];
			assign a_in   = div_a_sd[k-1];
			assign b_in   = div_b_sd[k-1];
			assign trial  = {rem_in, 1'b0};
		end

		if (k == DIV_STEPS - 1) begin : g_last_en
			assign div_en[k] = !div_vld_sd[k] || en_s4;
		end else begin : g_mid_en
			assign div_en[k] = !div_vld_sd[k] || div_en[k+1];
		end

		assign qbit = (trial >= {1'b0, rng_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_sd[k] <= 1'b0;
			end else if (div_en[k]) begin
				div_vld_sd[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (div_en[k]) begin
				div_rem_sd[k] <= qbit ? CTRL_BITS'(trial - {1'b0, rng_in})
				                      : trial[CTRL_BITS-1:0];
				div_rng_sd[k] <= rng_in;
				div_quo_sd[k] <= {quo_in[T_BITS-2:0], qbit};
				div_a_sd[k]   <= a_in;
				div_b_sd[k]   <= b_in;
			end
		end
	end

	// ---------------------------------------------------------------- s4: table positions (lane 0 = A, lane 1 = B)
	logic signed [SB-1:0] a_s4, b_s4;
	logic [T_BITS-1:0]    t_s4;
	logic [POS_BITS-1:0]  pos_s4 [2];
	logic [T_BITS-1:0]    t_div;

	assign t_div = div_quo_sd[DIV_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en_s4) begin
			vld_s4 <= div_vld_sd[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			a_s4      <= div_a_sd[DIV_STEPS-1];
			b_s4      <= div_b_sd[DIV_STEPS-1];
			t_s4      <= t_div;
			pos_s4[0] <= POS_BITS'(UNITY_Q16 - t_div) * TBL_N;
			pos_s4[1] <= POS_BITS'(t_div) * TBL_N;
		end
	end

	// ---------------------------------------------------------------- s5: table reads
	logic signed [SB-1:0]   a_s5, b_s5;
	logic [T_BITS-1:0]      t_s5;
	logic [T_BITS-1:0]      lo_s5   [2];
	logic [T_BITS-1:0]      hi_s5   [2];
	logic [FRAC_BITS-1:0]   frac_s5 [2];
	logic [IDX_BITS-1:0]    lut_idx [2];
	logic [IDX_BITS-1:0]    lut_lo  [2];
	logic [IDX_BITS-1:0]    lut_hi  [2];

	// past the last segment both taps read the end entry
	always_comb begin
		for (int g = 0; g < 2; g++) begin
			lut_idx[g] = pos_s4[g][POS_BITS-1:FRAC_BITS];
			if (lut_idx[g] < TBL_LAST) begin
				lut_lo[g] = lut_idx[g];
				lut_hi[g] = lut_idx[g] + 1'b1;
			end else begin
				lut_lo[g] = TBL_LAST;
				lut_hi[g] = TBL_LAST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en_s5) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			a_s5 <= a_s4;
			b_s5 <= b_s4;
			t_s5 <= t_s4;
			for (int g = 0; g < 2; g++) begin
				lo_s5[g]   <= sine_rom[lut_lo[g]];
				hi_s5[g]   <= sine_rom[lut_hi[g]];
				frac_s5[g] <= pos_s4[g][FRAC_BITS-1:0];
			end
		end
	end

	// ---------------------------------------------------------------- s6: interpolation product
	logic signed [SB-1:0] a_s6, b_s6;
	logic [T_BITS-1:0]    t_s6;
	logic [T_BITS-1:0]    lo_s6   [2];
	logic [PROD_BITS-1:0] prod_s6 [2];
	logic [T_BITS-1:0]    seg_diff [2];

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			seg_diff[g] = (hi_s5[g] > lo_s5[g]) ? (hi_s5[g] - lo_s5[g]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en_s6) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			a_s6 <= a_s5;
			b_s6 <= b_s5;
			t_s6 <= t_s5;
			for (int g = 0; g < 2; g++) begin
				lo_s6[g]   <= lo_s5[g];
				prod_s6[g] <= PROD_BITS'(seg_diff[g]) * PROD_BITS'(frac_s5[g]);
			end
		end
	end

	// ---------------------------------------------------------------- s7: gain law select
	logic signed [SB-1:0] a_s7, b_s7;
	logic [T_BITS-1:0]    gain_s7 [2];
	logic [T_BITS-1:0]    sine_gain [2];

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			sine_gain[g] = lo_s6[g] + prod_s6[g][PROD_BITS-1:FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en_s7) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			a_s7 <= a_s6;
			b_s7 <= b_s6;
			if (law_q == LAW_EQUAL_POWER) begin
				gain_s7[0] <= sine_gain[0];
				gain_s7[1] <= sine_gain[1];
			end else begin
				gain_s7[0] <= UNITY_Q16 - t_s6;
				gain_s7[1] <= t_s6;
			end
		end
	end

	// ---------------------------------------------------------------- s8: weight the samples
	logic signed [MUL_BITS-1:0] mul_s8 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en_s8) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			mul_s8[0] <= $signed({1'b0, gain_s7[0]}) * a_s7;
			mul_s8[1] <= $signed({1'b0, gain_s7[1]}) * b_s7;
		end
	end

	// ---------------------------------------------------------------- s9: sum, round half up, saturate
	logic [SB-1:0]             mixed_s9;
	logic                      sat_s9;
	logic signed [ACC_BITS-1:0] acc;
	logic signed [Q_BITS-1:0]   acc_q;

	assign acc   = ACC_BITS'(mul_s8[0]) + ACC_BITS'(mul_s8[1]) + ACC_BITS'(ROUND_HALF);
	assign acc_q = acc[ACC_BITS-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en_s9) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			if (acc_q > SAT_HI) begin
				mixed_s9 <= SAT_HI[SB-1:0];
				sat_s9   <= 1'b1;
			end else if (acc_q < SAT_LO) begin
				mixed_s9 <= SAT_LO[SB-1:0];
				sat_s9   <= 1'b1;
			end else begin
				mixed_s9 <= acc_q[SB-1:0];
				sat_s9   <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tdata  = OUT_DATA_BITS'(mixed_s9);
	assign m_axis_tuser  = sat_s9;

	// ---------------------------------------------------------------- checks
	`ACM_ASSERT_SAME(a_sat_on_rail, m_axis_tvalid && sat_s9, (mixed_s9 == SAT_HI[SB-1:0]) || (mixed_s9 == SAT_LO[SB-1:0]), "saturated result not on a rail")
	`ACM_ASSERT_SAME(a_pos_le_unity, div_vld_sd[DIV_STEPS-1], t_div <= UNITY_Q16, "crossfade position above 1.0")
	`ACM_ASSERT_SAME(a_linear_unity, vld_s7 && (law_q == LAW_LINEAR), (18'(gain_s7[0]) + 18'(gain_s7[1])) == 18'(UNITY_Q16), "linear gains do not sum to 1.0")
	`ACM_ASSERT_SAME(a_ready_drained, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule
`default_nettype wire
